FILE: rtl/lrupr_pkg.sv
// ----------------------------------------------------------------------------
// lrupr_pkg
// Shared types and constants of the LRU page replacement unit: frame count,
// page width, the search beat that walks the cell chain and the update beat.
// ----------------------------------------------------------------------------
package lrupr_pkg;

	localparam int FRAMES    = 8;
	localparam int PAGE_BITS = 8;

	// fixed field widths of the channels
	localparam int PAGE_W = 8;
	localparam int SLOT_W = 3;
	localparam int CFG_W  = 4;

	localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int CNT_W  = $clog2(FRAMES + 1);

	typedef logic [IDX_W-1:0]     idx_t;
	typedef logic [IDX_W-1:0]     age_t;
	typedef logic [PAGE_BITS-1:0] page_t;
	typedef logic [CNT_W-1:0]     cnt_t;

	localparam age_t AGE_MAX = IDX_W'(FRAMES - 1);

	// search beat handed from cell to cell
	typedef struct packed {
		logic  vld;
		page_t page;
		logic  hit;
		idx_t  hit_idx;
		age_t  hit_age;
		logic  emp_found;
		idx_t  emp_idx;
		logic  old_set;
		idx_t  old_idx;
		age_t  old_age;
		page_t old_page;
	} srch_t;

	// update beat broadcast to every cell
	typedef struct packed {
		logic  vld;
		idx_t  slot;
		logic  all;
		age_t  limit;
		logic  wr;
		page_t page;
	} upd_t;

endpackage

FILE: rtl/lrupr_in_if.sv
// ----------------------------------------------------------------------------
// lrupr_in_if
// Page reference channel: valid, ready and the referenced page.
// ----------------------------------------------------------------------------
interface lrupr_in_if;
	import lrupr_pkg::*;

	logic              valid;
	logic              ready;
	logic [PAGE_W-1:0] page;

	modport source (output valid, output page, input ready);
	modport sink   (input valid, input page, output ready);
endinterface

FILE: rtl/lrupr_out_if.sv
// ----------------------------------------------------------------------------
// lrupr_out_if
// Result channel: hit flag, frame slot and the evicted page if any.
// ----------------------------------------------------------------------------
interface lrupr_out_if;
	import lrupr_pkg::*;

	logic              valid;
	logic              ready;
	logic              hit;
	logic [SLOT_W-1:0] slot;
	logic              evicted_valid;
	logic [PAGE_W-1:0] evicted_page;

	modport source (output valid, output hit, output slot, output evicted_valid,
		output evicted_page, input ready);
	modport sink   (input valid, input hit, input slot, input evicted_valid,
		input evicted_page, output ready);
endinterface

FILE: rtl/lrupr_cfg_if.sv
// ----------------------------------------------------------------------------
// lrupr_cfg_if
// Configuration write channel carrying the frames_used value.
// ----------------------------------------------------------------------------
interface lrupr_cfg_if;
	import lrupr_pkg::*;

	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/lrupr_cell.sv
// ----------------------------------------------------------------------------
// lrupr_cell
// One page frame: page tag, valid bit and recency age. Folds its frame into
// the passing search beat and applies the broadcast age update.
// ----------------------------------------------------------------------------
module lrupr_cell
	import lrupr_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  idx_t  idx,
	input  logic  act,
	input  srch_t srch_i,
	output srch_t srch_o,
	input  upd_t  upd
);

	page_t page_q;
	logic  valid_q;
	age_t  age_q;
	srch_t srch_q;
	srch_t srch_nxt;

	// fold this frame into the search beat
	always_comb begin
		srch_nxt = srch_i;
		if (act) begin
			if (valid_q && page_q == srch_i.page && !srch_i.hit) begin
				srch_nxt.hit     = 1'b1;
				srch_nxt.hit_idx = idx;
				srch_nxt.hit_age = age_q;
			end
			if (!valid_q && !srch_i.emp_found) begin
				srch_nxt.emp_found = 1'b1;
				srch_nxt.emp_idx   = idx;
			end
			if (!srch_i.old_set || age_q > srch_i.old_age) begin
				srch_nxt.old_set  = 1'b1;
				srch_nxt.old_idx  = idx;
				srch_nxt.old_age  = age_q;
				srch_nxt.old_page = page_q;
			end
		end
	end

	// hand the beat to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			srch_q <= '0;
		end else begin
			srch_q <= srch_nxt;
		end
	end

	assign srch_o = srch_q;

	// valid bit and age
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			age_q   <= '0;
		end else if (upd.vld) begin
			if (idx == upd.slot) begin
				age_q <= '0;
				if (upd.wr) begin
					valid_q <= 1'b1;
				end
			end else if (act && valid_q && (upd.all || age_q < upd.limit) &&
				age_q < AGE_MAX) begin
				age_q <= age_q + age_t'(1);
			end
		end
	end

	// page tag, written on fill or replace
	always_ff @(posedge clk) begin
		if (upd.vld && idx == upd.slot && upd.wr) begin
			page_q <= upd.page;
		end
	end

endmodule

FILE: rtl/lru_page_replacement.sv
// ----------------------------------------------------------------------------
// lru_page_replacement
// LRU page replacement unit built as a chain of frame cells.
// ----------------------------------------------------------------------------
// Usage:
//   ref_in  : one page reference per beat (valid/ready).
//   res_out : one result per reference: hit, slot, evicted_valid and
//             evicted_page (zero when nothing was evicted).
//   cfg     : frames_used write; 0 acts as 1, values above FRAMES act as
//             FRAMES. Write only while no reference is outstanding.
// Timing: an accepted reference walks the FRAMES cells one cell per cycle,
//   is held in the pending register for the decision, and its commit,
//   once the result register is free, updates the ages and loads the
//   result register. A new reference is taken only after the previous
//   one has committed, so at most one walks the cell chain.
// Stall: while res_out is stalled a following reference still walks the
//   chain; its commit waits until the result register is free.
// Reset: all frames become empty with age zero, frames_used becomes 8;
//   references are accepted in the first cycle after reset.
// ----------------------------------------------------------------------------
module lru_page_replacement
	import lrupr_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	lrupr_in_if.sink     ref_in,
	lrupr_out_if.source  res_out,
	lrupr_cfg_if.sink    cfg
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_COMMIT
	} state_t;

	state_t            state_q;
	logic [CFG_W-1:0]  frames_used_q;
	cnt_t              act_n;
	logic [FRAMES-1:0] act;
	logic [FRAMES-1:0] chain_vld;
	srch_t             chain [FRAMES+1];
	srch_t             pend_q;
	upd_t              upd;
	logic              in_acc;
	logic              out_free;
	logic              commit;

	logic              out_vld_q;
	logic              out_hit_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic              out_ev_q;
	logic [PAGE_W-1:0] out_evp_q;

	// configuration register
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_used_q <= CFG_W'(8);
		end else if (cfg.valid) begin
			frames_used_q <= cfg.data;
		end
	end

	// clamp active frame count and derive per-cell enables
	always_comb begin
		if (frames_used_q == '0) begin
			act_n = cnt_t'(1);
		end else if ({1'b0, frames_used_q} > (CFG_W+1)'(FRAMES)) begin
			act_n = cnt_t'(FRAMES);
		end else begin
			act_n = cnt_t'(frames_used_q);
		end
	end

	for (genvar k = 0; k < FRAMES; k++) begin : g_act
		assign act[k] = cnt_t'(k) < act_n;
	end

	// inject a fresh search beat at the head of the chain
	assign ref_in.ready = (state_q == S_IDLE);
	assign in_acc       = ref_in.valid && ref_in.ready;

	always_comb begin
		chain[0]      = '0;
		chain[0].vld  = in_acc;
		chain[0].page = ref_in.page[PAGE_BITS-1:0];
	end

	// row of frame cells
	for (genvar k = 0; k < FRAMES; k++) begin : g_cell
		lrupr_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.idx    (idx_t'(k)),
			.act    (act[k]),
			.srch_i (chain[k]),
			.srch_o (chain[k+1]),
			.upd    (upd)
		);
		assign chain_vld[k] = chain[k+1].vld;
	end

	// decision from the finished search beat
	assign out_free = !out_vld_q || res_out.ready;
	assign commit   = (state_q == S_COMMIT) && out_free;

	always_comb begin
		upd      = '0;
		upd.vld  = commit;
		upd.page = pend_q.page;
		priority if (pend_q.hit) begin
			upd.slot  = pend_q.hit_idx;
			upd.limit = pend_q.hit_age;
		end else if (pend_q.emp_found) begin
			upd.slot = pend_q.emp_idx;
			upd.all  = 1'b1;
			upd.wr   = 1'b1;
		end else begin
			upd.slot  = pend_q.old_idx;
			upd.limit = pend_q.old_age;
			upd.wr    = 1'b1;
		end
	end

	// sequencer, result register and pending beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			out_vld_q  <= 1'b0;
			out_hit_q  <= 1'b0;
			out_slot_q <= '0;
			out_ev_q   <= 1'b0;
			out_evp_q  <= '0;
			pend_q     <= '0;
		end else begin
			if (out_vld_q && res_out.ready && !commit) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (chain[FRAMES].vld) begin
						pend_q  <= chain[FRAMES];
						state_q <= S_COMMIT;
					end
				end
				S_COMMIT: begin
					if (out_free) begin
						out_vld_q  <= 1'b1;
						out_hit_q  <= pend_q.hit;
						out_slot_q <= SLOT_W'(upd.slot);
						out_ev_q   <= !pend_q.hit && !pend_q.emp_found;
						out_evp_q  <= (!pend_q.hit && !pend_q.emp_found) ?
							PAGE_W'(pend_q.old_page) : '0;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign res_out.valid         = out_vld_q;
	assign res_out.hit           = out_hit_q;
	assign res_out.slot          = out_slot_q;
	assign res_out.evicted_valid = out_ev_q;
	assign res_out.evicted_page  = out_evp_q;

	// at most one search beat in the chain
	a_one_beat: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(chain_vld) <= 1)
		else $error("more than one search beat in the cell chain");

	// no new reference while a beat walks or waits
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(chain_vld != '0 || state_q == S_COMMIT) |-> !ref_in.ready)
		else $error("reference accepted while unit busy");

	// a commit always presents a result next cycle
	a_commit_out: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> (res_out.valid && state_q == S_IDLE))
		else $error("commit did not load the result register");

	// hit and eviction exclude each other, no eviction means zero page
	a_ev_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_out.valid |-> (!(res_out.hit && res_out.evicted_valid) &&
		(res_out.evicted_valid || res_out.evicted_page == '0)))
		else $error("inconsistent eviction fields");

endmodule
